/* hw/rtl/mst_pkg.sv */
// ----------------------------------------------------------------------------
// mst_pkg: motor status frame table shared definitions
// Command codes, frame checks, pipeline item and table request/response types.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int CONTROLLERS_DEF = 8;

  localparam logic       OP_FRAME    = 1'b0;
  localparam logic       OP_QUERY    = 1'b1;
  localparam logic [7:0] CMD_SPEED   = 8'd9;
  localparam logic [7:0] CMD_TEMPS   = 8'd16;
  localparam logic [7:0] CMD_VOLTS   = 8'd27;
  localparam logic [3:0] FRAME_BYTES = 4'd8;

  typedef struct packed {
    logic        operation;
    logic        is_extended;
    logic [28:0] frame_id;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic [7:0]  query_id;
  } mst_item_t;

  typedef struct packed {
    logic        frame_we;
    logic        query_re;
    logic [7:0]  who;
    logic [7:0]  cmd;
    logic [63:0] data;
  } mst_req_t;

  typedef struct packed {
    logic have;
    logic spd_ok;
    logic tmp_ok;
    logic vlt_ok;
  } mst_rsp_t;

endpackage

/* hw/rtl/mst_if.sv */
// ----------------------------------------------------------------------------
// mst_if: valid/ready channels of the motor status frame table
// Input channel carries frames and queries; output channel carries status.
// ----------------------------------------------------------------------------
interface mst_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        is_extended;
  logic [28:0] frame_id;
  logic [3:0]  data_length;
  logic [63:0] payload;
  logic [7:0]  query_id;

  modport source (output valid, operation, is_extended, frame_id, data_length,
                  payload, query_id, input ready);
  modport sink   (input valid, operation, is_extended, frame_id, data_length,
                  payload, query_id, output ready);
endinterface

interface mst_out_if;
  logic               valid;
  logic               ready;
  logic               have_data;
  logic [7:0]         controller;
  logic signed [31:0] erpm;
  logic signed [15:0] motor_current;
  logic signed [15:0] duty;
  logic signed [15:0] fet_temp;
  logic signed [15:0] motor_temp;
  logic signed [15:0] input_voltage;

  modport source (output valid, have_data, controller, erpm, motor_current, duty,
                  fet_temp, motor_temp, input_voltage, input ready);
  modport sink   (input valid, have_data, controller, erpm, motor_current, duty,
                  fet_temp, motor_temp, input_voltage, output ready);
endinterface

/* hw/rtl/motor_status_frame_table_unit.sv */
// ----------------------------------------------------------------------------
// motor_status_frame_table_unit: CAN motor controller status table
// Captures status frames into a per-controller table and answers queries.
// ----------------------------------------------------------------------------
// Each input-channel transfer is registered; a frame updates the table in the
// next cycle, and a query reads it into the output register once the output
// can advance. One item can be accepted every cycle unless a query waits on a
// stalled output. A frame is stored only with link_ready set, an extended
// identifier and a length of 8; a query returns one result and consumes the
// fresh mark. The table storage is one write and one read per cycle; per-entry
// valid bits make the table read as zero after reset with no clearing pass.
module motor_status_frame_table_unit #(
  parameter int CONTROLLERS = mst_pkg::CONTROLLERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  mst_in_if.sink    in_ch,
  mst_out_if.source out_ch
);
  import mst_pkg::*;

  logic      link_ready_r;
  logic      s1_valid_r, s1_valid_nxt;
  mst_item_t s1_r;
  logic      out_valid_r, out_valid_nxt;
  logic [7:0] ctrl_r;

  logic      s1_query, s1_go, out_adv, in_take;
  mst_req_t  req;
  mst_rsp_t  rsp;
  logic [31:0] rd_spd;
  logic [15:0] rd_cur, rd_duty, rd_fet, rd_mot, rd_vlt;

  assign s1_query = (s1_r.operation == OP_QUERY);
  assign out_adv  = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && (!s1_query || out_adv);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_comb begin
    req.frame_we = s1_valid_r && !s1_query && link_ready_r && s1_r.is_extended &&
                   (s1_r.data_length == FRAME_BYTES);
    req.query_re = s1_valid_r && s1_query && out_adv;
    req.who      = s1_query ? s1_r.query_id : s1_r.frame_id[7:0];
    req.cmd      = s1_r.frame_id[15:8];
    req.data     = s1_r.payload;
  end

  always_comb begin
    s1_valid_nxt = in_take || (s1_valid_r && !s1_go);
    if (req.query_re) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_ready_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        link_ready_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.operation   <= in_ch.operation;
      s1_r.is_extended <= in_ch.is_extended;
      s1_r.frame_id    <= in_ch.frame_id;
      s1_r.data_length <= in_ch.data_length;
      s1_r.payload     <= in_ch.payload;
      s1_r.query_id    <= in_ch.query_id;
    end
    if (req.query_re) begin
      ctrl_r <= s1_r.query_id;
    end
  end

  mst_table #(
    .CONTROLLERS(CONTROLLERS)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .rsp    (rsp),
    .rd_spd (rd_spd),
    .rd_cur (rd_cur),
    .rd_duty(rd_duty),
    .rd_fet (rd_fet),
    .rd_mot (rd_mot),
    .rd_vlt (rd_vlt)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.have_data     = rsp.have;
  assign out_ch.controller    = ctrl_r;
  assign out_ch.erpm          = rsp.spd_ok ? signed'(rd_spd)  : 32'sd0;
  assign out_ch.motor_current = rsp.spd_ok ? signed'(rd_cur)  : 16'sd0;
  assign out_ch.duty          = rsp.spd_ok ? signed'(rd_duty) : 16'sd0;
  assign out_ch.fet_temp      = rsp.tmp_ok ? signed'(rd_fet)  : 16'sd0;
  assign out_ch.motor_temp    = rsp.tmp_ok ? signed'(rd_mot)  : 16'sd0;
  assign out_ch.input_voltage = rsp.vlt_ok ? signed'(rd_vlt)  : 16'sd0;

  // only a query makes a result
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_query))
    else $error("result without query");

  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_query && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while query stalled");

  a_no_write_down: assert property (@(posedge clk) disable iff (!rst_n)
    !link_ready_r |-> !req.frame_we)
    else $error("frame stored with link down");

endmodule

/* hw/rtl/mst_table.sv */
// ----------------------------------------------------------------------------
// mst_table: per-controller status storage
// Stores status frame fields per controller, tracks fresh marks, and returns
// a registered read on query with per-group valid flags.
// ----------------------------------------------------------------------------
module mst_table #(
  parameter int CONTROLLERS = mst_pkg::CONTROLLERS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mst_pkg::mst_req_t req,
  output mst_pkg::mst_rsp_t rsp,
  output logic [31:0]      rd_spd,
  output logic [15:0]      rd_cur,
  output logic [15:0]      rd_duty,
  output logic [15:0]      rd_fet,
  output logic [15:0]      rd_mot,
  output logic [15:0]      rd_vlt
);
  import mst_pkg::*;

  localparam int IDX_W = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;

  logic [31:0] spd_mem  [CONTROLLERS];
  logic [15:0] cur_mem  [CONTROLLERS];
  logic [15:0] duty_mem [CONTROLLERS];
  logic [15:0] fet_mem  [CONTROLLERS];
  logic [15:0] mot_mem  [CONTROLLERS];
  logic [15:0] vlt_mem  [CONTROLLERS];

  logic [CONTROLLERS-1:0] spd_vld_r, tmp_vld_r, vlt_vld_r, fresh_r;
  logic [CONTROLLERS-1:0] spd_vld_nxt, tmp_vld_nxt, vlt_vld_nxt, fresh_nxt;

  logic [31:0] rd_spd_r;
  logic [15:0] rd_cur_r, rd_duty_r, rd_fet_r, rd_mot_r, rd_vlt_r;
  mst_rsp_t    rsp_r, rsp_nxt;

  logic             in_range;
  logic [7:0]       slot_full;
  logic [IDX_W-1:0] slot;
  logic             we_spd, we_tmp, we_vlt;

  assign in_range  = (req.who != 8'd0) && (req.who <= 8'(CONTROLLERS));
  assign slot_full = req.who - 8'd1;
  assign slot      = in_range ? slot_full[IDX_W-1:0] : '0;

  assign we_spd = req.frame_we && in_range && (req.cmd == CMD_SPEED);
  assign we_tmp = req.frame_we && in_range && (req.cmd == CMD_TEMPS);
  assign we_vlt = req.frame_we && in_range && (req.cmd == CMD_VOLTS);

  always_comb begin
    spd_vld_nxt = spd_vld_r;
    tmp_vld_nxt = tmp_vld_r;
    vlt_vld_nxt = vlt_vld_r;
    fresh_nxt   = fresh_r;
    rsp_nxt     = rsp_r;
    if (we_spd) begin
      spd_vld_nxt[slot] = 1'b1;
    end
    if (we_tmp) begin
      tmp_vld_nxt[slot] = 1'b1;
    end
    if (we_vlt) begin
      vlt_vld_nxt[slot] = 1'b1;
    end
    if (we_spd || we_tmp || we_vlt) begin
      fresh_nxt[slot] = 1'b1;
    end
    if (req.query_re) begin
      rsp_nxt.have   = in_range && fresh_r[slot];
      rsp_nxt.spd_ok = rsp_nxt.have && spd_vld_r[slot];
      rsp_nxt.tmp_ok = rsp_nxt.have && tmp_vld_r[slot];
      rsp_nxt.vlt_ok = rsp_nxt.have && vlt_vld_r[slot];
      if (rsp_nxt.have) begin
        fresh_nxt[slot] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_vld_r <= '0;
      tmp_vld_r <= '0;
      vlt_vld_r <= '0;
      fresh_r   <= '0;
      rsp_r     <= '0;
    end else begin
      spd_vld_r <= spd_vld_nxt;
      tmp_vld_r <= tmp_vld_nxt;
      vlt_vld_r <= vlt_vld_nxt;
      fresh_r   <= fresh_nxt;
      rsp_r     <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we_spd) begin
      spd_mem[slot]  <= req.data[63:32];
      cur_mem[slot]  <= req.data[31:16];
      duty_mem[slot] <= req.data[15:0];
    end
    if (we_tmp) begin
      fet_mem[slot] <= req.data[63:48];
      mot_mem[slot] <= req.data[47:32];
    end
    if (we_vlt) begin
      vlt_mem[slot] <= req.data[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (req.query_re) begin
      rd_spd_r  <= spd_mem[slot];
      rd_cur_r  <= cur_mem[slot];
      rd_duty_r <= duty_mem[slot];
      rd_fet_r  <= fet_mem[slot];
      rd_mot_r  <= mot_mem[slot];
      rd_vlt_r  <= vlt_mem[slot];
    end
  end

  assign rsp     = rsp_r;
  assign rd_spd  = rd_spd_r;
  assign rd_cur  = rd_cur_r;
  assign rd_duty = rd_duty_r;
  assign rd_fet  = rd_fet_r;
  assign rd_mot  = rd_mot_r;
  assign rd_vlt  = rd_vlt_r;

  // a fresh entry always has at least one group written
  a_fresh_backed: assert property (@(posedge clk) disable iff (!rst_n)
    (fresh_r & ~(spd_vld_r | tmp_vld_r | vlt_vld_r)) == '0)
    else $error("fresh mark without stored data");

  a_fresh_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    req.query_re && rsp_nxt.have |=> !fresh_r[$past(slot)])
    else $error("fresh mark survived a hit query");

  a_rsp_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_r.spd_ok || rsp_r.tmp_ok || rsp_r.vlt_ok) |-> rsp_r.have)
    else $error("group flag set without hit");

endmodule

/* test/motor_status_frame_table_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_status_frame_table_unit_tb: self-checking bench for the status table
// Streams CAN status frames and status queries through the input channel.
// A local table model predicts every query response, and each response is
// checked field by field in order of arrival. The run covers the link-down
// state, malformed frames, out-of-range controllers, and random mixes. It
// also uses random idle cycles on both channels, a long output stall, and a
// final stretch at full rate.
// ----------------------------------------------------------------------------
module motor_status_frame_table_unit_tb;
  import mst_pkg::*;

  typedef struct packed {
    logic               have;
    logic [7:0]         controller;
    logic signed [31:0] erpm;
    logic signed [15:0] current;
    logic signed [15:0] duty;
    logic signed [15:0] fet;
    logic signed [15:0] mtemp;
    logic signed [15:0] volt;
  } status_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  mst_in_if  in_ch();
  mst_out_if out_ch();

  motor_status_frame_table_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #5 clk = ~clk;

  // table model
  logic               link_up_model;
  logic signed [31:0] erpm_tbl  [CONTROLLERS_DEF];
  logic signed [15:0] cur_tbl   [CONTROLLERS_DEF];
  logic signed [15:0] duty_tbl  [CONTROLLERS_DEF];
  logic signed [15:0] fet_tbl   [CONTROLLERS_DEF];
  logic signed [15:0] mtemp_tbl [CONTROLLERS_DEF];
  logic signed [15:0] volt_tbl  [CONTROLLERS_DEF];
  logic               fresh_tbl [CONTROLLERS_DEF];

  mst_item_t item_pending_q[$];
  status_t   status_expect_q[$];

  mst_item_t offered = '0;
  logic      offered_live = 1'b0;
  int        send_gap;
  int        recv_stall;
  logic      quiet = 1'b0;
  logic      sink_hold = 1'b0;
  logic      backlog_go = 1'b0;

  int err_count;
  int items_moved;
  int frames_stored;
  int answers_full;
  int answers_empty;

  task automatic table_step(input mst_item_t it);
    logic [7:0] who;
    logic [7:0] cmd;
    int         slot;
    status_t    r;
    who = (it.operation == OP_FRAME) ? it.frame_id[7:0] : it.query_id;
    cmd = it.frame_id[15:8];
    slot = int'(who) - 1;
    if (it.operation == OP_FRAME) begin
      if (link_up_model && it.is_extended && it.data_length == FRAME_BYTES &&
          who >= 8'd1 && who <= 8'(CONTROLLERS_DEF)) begin
        case (cmd)
          CMD_SPEED: begin
            erpm_tbl[slot] = it.payload[63:32];
            cur_tbl[slot]  = it.payload[31:16];
            duty_tbl[slot] = it.payload[15:0];
            fresh_tbl[slot] = 1'b1;
            frames_stored++;
          end
          CMD_TEMPS: begin
            fet_tbl[slot]   = it.payload[63:48];
            mtemp_tbl[slot] = it.payload[47:32];
            fresh_tbl[slot] = 1'b1;
            frames_stored++;
          end
          CMD_VOLTS: begin
            volt_tbl[slot] = it.payload[31:16];
            fresh_tbl[slot] = 1'b1;
            frames_stored++;
          end
          default: ;
        endcase
      end
    end else begin
      r = '0;
      r.controller = who;
      if (who >= 8'd1 && who <= 8'(CONTROLLERS_DEF) && fresh_tbl[slot]) begin
        r.have    = 1'b1;
        r.erpm    = erpm_tbl[slot];
        r.current = cur_tbl[slot];
        r.duty    = duty_tbl[slot];
        r.fet     = fet_tbl[slot];
        r.mtemp   = mtemp_tbl[slot];
        r.volt    = volt_tbl[slot];
        fresh_tbl[slot] = 1'b0;
      end
      status_expect_q.push_back(r);
    end
  endtask

  function automatic mst_item_t mk_frame(logic ext, logic [3:0] len, logic [28:0] id,
                                         logic [63:0] data);
    mst_item_t it;
    it.operation   = OP_FRAME;
    it.is_extended = ext;
    it.frame_id    = id;
    it.data_length = len;
    it.payload     = data;
    it.query_id    = 8'($urandom);
    return it;
  endfunction

  function automatic mst_item_t mk_query(logic [7:0] who);
    mst_item_t it;
    it.operation   = OP_QUERY;
    it.is_extended = 1'($urandom);
    it.frame_id    = 29'($urandom);
    it.data_length = 4'($urandom);
    it.payload     = {$urandom, $urandom};
    it.query_id    = who;
    return it;
  endfunction

  function automatic mst_item_t rand_item();
    logic [28:0] id;
    logic [7:0]  cmd;
    logic [7:0]  who;
    int          pick;
    id   = 29'($urandom);
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) who = 8'($urandom);
    else who = 8'($urandom_range(1, CONTROLLERS_DEF));
    case ($urandom_range(0, 2))
      0: cmd = CMD_SPEED;
      1: cmd = CMD_TEMPS;
      default: cmd = CMD_VOLTS;
    endcase
    if (pick < 40) return mk_query(who);
    if (pick < 85) begin
      id[15:0] = {cmd, who};
      return mk_frame(1'b1, FRAME_BYTES, id, {$urandom, $urandom});
    end
    // malformed or off-table frame
    if ($urandom_range(0, 1) == 0) id[15:8] = cmd;
    if ($urandom_range(0, 1) == 0) id[7:0] = 8'($urandom_range(0, 15));
    return mk_frame(1'($urandom), 4'($urandom_range(0, 15)), id, {$urandom, $urandom});
  endfunction

  task automatic queue_random(input int n);
    repeat (n) item_pending_q.push_back(rand_item());
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (item_pending_q.size() != 0 || offered_live || status_expect_q.size() != 0);
    // frames produce no response; let the last one retire
    repeat (4) @(negedge clk);
  endtask

  task automatic set_link_ready(input logic v);
    wait_drained();
    @(posedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    link_up_model = v;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : frame_driver
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.operation   <= OP_FRAME;
      in_ch.is_extended <= 1'b0;
      in_ch.frame_id    <= '0;
      in_ch.data_length <= '0;
      in_ch.payload     <= '0;
      in_ch.query_id    <= '0;
      offered_live = 1'b0;
      send_gap     = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        table_step(offered);
        items_moved++;
        offered_live = 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
      end
      if (!offered_live) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (item_pending_q.size() > 0) begin
          offered      = item_pending_q.pop_front();
          offered_live = 1'b1;
        end
      end
      in_ch.valid       <= offered_live;
      in_ch.operation   <= offered.operation;
      in_ch.is_extended <= offered.is_extended;
      in_ch.frame_id    <= offered.frame_id;
      in_ch.data_length <= offered.data_length;
      in_ch.payload     <= offered.payload;
      in_ch.query_id    <= offered.query_id;
    end
  end

  always @(posedge clk) begin : status_monitor
    status_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (status_expect_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual controller %0d",
                   $time, out_ch.controller);
          err_count++;
        end else begin
          want = status_expect_q.pop_front();
          check_field("have_data", 32'(want.have), 32'(out_ch.have_data));
          check_field("controller", 32'(want.controller), 32'(out_ch.controller));
          check_field("erpm", want.erpm, out_ch.erpm);
          check_field("motor_current", 32'(want.current), 32'(out_ch.motor_current));
          check_field("duty", 32'(want.duty), 32'(out_ch.duty));
          check_field("fet_temp", 32'(want.fet), 32'(out_ch.fet_temp));
          check_field("motor_temp", 32'(want.mtemp), 32'(out_ch.motor_temp));
          check_field("input_voltage", 32'(want.volt), 32'(out_ch.input_voltage));
          if (want.have) answers_full++;
          else answers_empty++;
        end
      end
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : long_backpressure
    wait (backlog_go);
    @(negedge clk);
    sink_hold = 1'b1;
    repeat (80) @(negedge clk);
    sink_hold = 1'b0;
  end

  initial begin : watchdog
    #3_000_000;
    $display("motor_status_frame_table_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    link_up_model     = 1'b0;
    for (int i = 0; i < CONTROLLERS_DEF; i++) begin
      erpm_tbl[i] = '0; cur_tbl[i] = '0; duty_tbl[i] = '0;
      fet_tbl[i] = '0; mtemp_tbl[i] = '0; volt_tbl[i] = '0;
      fresh_tbl[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // link down after reset: queries see an empty table, frames are dropped
    item_pending_q.push_back(mk_query(8'd1));
    item_pending_q.push_back(mk_query(8'd0));
    item_pending_q.push_back(mk_query(8'd255));
    item_pending_q.push_back(mk_frame(1'b1, FRAME_BYTES, {13'h0, CMD_SPEED, 8'd1},
                                      64'h1234_5678_9ABC_DEF0));
    item_pending_q.push_back(mk_query(8'd1));
    set_link_ready(1'b1);

    item_pending_q.push_back(mk_frame(1'b1, FRAME_BYTES, {13'h0, CMD_SPEED, 8'd1},
                                      64'h7FFF_FFFF_8000_7FFF));
    item_pending_q.push_back(mk_frame(1'b1, FRAME_BYTES, {13'h0, CMD_TEMPS, 8'd1},
                                      64'h8000_7FFF_FFFF_FFFF));
    item_pending_q.push_back(mk_frame(1'b1, FRAME_BYTES, {13'h0, CMD_VOLTS, 8'd1},
                                      64'hFFFF_FFFF_8000_FFFF));
    item_pending_q.push_back(mk_query(8'd1));
    item_pending_q.push_back(mk_query(8'd1));
    // standard id and bad lengths are dropped
    item_pending_q.push_back(mk_frame(1'b0, FRAME_BYTES, {13'h0, CMD_SPEED, 8'd2},
                                      64'hFFFF_FFFF_FFFF_FFFF));
    item_pending_q.push_back(mk_frame(1'b1, 4'd7, {13'h0, CMD_SPEED, 8'd2},
                                      64'hFFFF_FFFF_FFFF_FFFF));
    item_pending_q.push_back(mk_frame(1'b1, 4'd15, {13'h0, CMD_TEMPS, 8'd2},
                                      64'hFFFF_FFFF_FFFF_FFFF));
    item_pending_q.push_back(mk_frame(1'b1, 4'd9, {13'h0, CMD_VOLTS, 8'd2},
                                      64'hFFFF_FFFF_FFFF_FFFF));
    item_pending_q.push_back(mk_query(8'd2));
    // controllers off the table
    item_pending_q.push_back(mk_frame(1'b1, FRAME_BYTES, {13'h0, CMD_SPEED, 8'd0},
                                      64'h0123_4567_89AB_CDEF));
    item_pending_q.push_back(mk_frame(1'b1, FRAME_BYTES, {13'h0, CMD_TEMPS, 8'd9},
                                      64'h0123_4567_89AB_CDEF));
    item_pending_q.push_back(mk_query(8'd9));
    // unknown command, then upper id bits ignored
    item_pending_q.push_back(mk_frame(1'b1, FRAME_BYTES, {13'h0, 8'd10, 8'd3},
                                      64'h0123_4567_89AB_CDEF));
    item_pending_q.push_back(mk_query(8'd3));
    item_pending_q.push_back(mk_frame(1'b1, FRAME_BYTES, {13'h1FFF, CMD_SPEED, 8'd3},
                                      64'h8000_0000_8000_8000));
    item_pending_q.push_back(mk_query(8'd3));
    item_pending_q.push_back(mk_frame(1'b1, FRAME_BYTES, {13'h0, CMD_VOLTS, 8'd8},
                                      {$urandom, $urandom}));
    item_pending_q.push_back(mk_frame(1'b1, FRAME_BYTES, {13'h0, CMD_TEMPS, 8'd8},
                                      64'h0));
    item_pending_q.push_back(mk_query(8'd8));
    wait_drained();

    queue_random(180);
    set_link_ready(1'b0);
    queue_random(60);
    set_link_ready(1'b1);

    // output held off while the sender keeps going
    backlog_go = 1'b1;
    queue_random(160);
    wait_drained();

    queue_random(160);
    wait_drained();
    quiet = 1'b1;
    queue_random(120);
    wait_drained();
    repeat (6) @(posedge clk);

    $display("%0d transfers in, %0d frames stored, %0d answers with data, %0d without",
             items_moved, frames_stored, answers_full, answers_empty);
    $display("link up and down, malformed frames, long output stall, full-rate tail");
    if (err_count == 0) begin
      $display("motor_status_frame_table_unit verification clean");
    end else begin
      $display("motor_status_frame_table_unit verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mst_pkg.sv
hw/rtl/mst_if.sv
hw/rtl/mst_table.sv
hw/rtl/motor_status_frame_table_unit.sv
test/motor_status_frame_table_unit_tb.sv
